### hdl/srtf_job_scheduler_macros.svh
// assertion macros for the srtf job scheduler
// used by the top level only, needs clk and rst_n in scope
`ifndef SRTF_JOB_SCHEDULER_MACROS_SVH
`define SRTF_JOB_SCHEDULER_MACROS_SVH

// checked only while out of reset
`define SRTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SRTF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/srtf_pkg.sv
// shared types and constants for the srtf job scheduler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package srtf_pkg;

  localparam int SLOTS_DEF = 16;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_IDLE   = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;
  localparam logic [1:0] STAT_ZERO   = 2'd3;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;
  localparam logic [39:0] SUM_MAX  = 40'hFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_WAITC,
    ST_SUMS,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
  } slot_t;

  typedef struct packed {
    logic clr;
    logic vld;
  } pick_ctl_t;

endpackage

`default_nettype wire

### hdl/srtf_pick.sv
// shared compare unit: keeps the best eligible slot seen during a scan
// depends on srtf_pkg
`timescale 1ns / 1ps
`default_nettype none

module srtf_pick #(
  parameter int IW = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire srtf_pkg::pick_ctl_t ctl,
  input  wire logic [IW-1:0]     cand_idx,
  input  wire srtf_pkg::slot_t   cand,
  input  wire logic [31:0]       clock_time,
  output logic                   found,
  output logic [IW-1:0]          best_idx,
  output srtf_pkg::slot_t        best
);
  import srtf_pkg::*;

  logic          found_r, found_nxt;
  logic [IW-1:0] best_idx_r;
  slot_t         best_r;
  logic          eligible;
  logic          better;
  logic          take;

  always_comb begin
    eligible = ({16'd0, cand.arrival} <= clock_time) && (cand.remaining != 16'd0);
    better   = !found_r
            || (cand.remaining < best_r.remaining)
            || ((cand.remaining == best_r.remaining) && (cand.arrival < best_r.arrival));
    take     = ctl.vld && eligible && better;
    if (ctl.clr) begin
      found_nxt = 1'b0;
    end else if (take) begin
      found_nxt = 1'b1;
    end else begin
      found_nxt = found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !ctl.clr) begin
      best_idx_r <= cand_idx;
      best_r     <= cand;
    end
  end

  assign found    = found_r;
  assign best_idx = best_idx_r;
  assign best     = best_r;

endmodule

`default_nettype wire

### hdl/srtf_job_scheduler.sv
// Preemptive shortest-remaining-time-first scheduler with a job table of SLOTS entries.
// A clear or add beat goes from idle to the result state; a tick beat scans the table,
// reading one table entry per cycle from the one-read, one-write slot memory through
// one shared compare unit, then decides; when the chosen job finishes, the completion
// arithmetic runs in the WAITC and SUMS states. The result state waits while the output
// register holds a result not yet taken. The input is not ready while a beat is in work;
// a finished result waits in the output register while the next beat is taken. No clearing pass.
// depends on srtf_pkg, srtf_pick and srtf_job_scheduler_macros.svh
`timescale 1ns / 1ps
`default_nettype none

module srtf_job_scheduler #(
  parameter int SLOTS = srtf_pkg::SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [15:0] in_arrival,
  input  wire logic [15:0] in_burst,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [4:0]       out_job_id,
  output logic             out_job_finished,
  output logic [31:0]      out_turnaround,
  output logic [31:0]      out_waiting,
  output logic [31:0]      out_time_now,
  output logic [4:0]       out_done_count,
  output logic             out_all_done,
  output logic [39:0]      out_waiting_sum,
  output logic [39:0]      out_turnaround_sum
);
  import srtf_pkg::*;
  `include "srtf_job_scheduler_macros.svh"

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] FULL = CW'(SLOTS);

  state_t        state_r, state_nxt;
  logic [CW-1:0] issue_idx_r, issue_idx_nxt;
  logic          rd_vld_r;
  logic [IW-1:0] rd_idx_r;
  slot_t         rd_data_r;
  logic [CW-1:0] jobs_stored_r, jobs_stored_nxt;
  logic [CW-1:0] jobs_completed_r, jobs_completed_nxt;
  logic [31:0]   clock_time_r, clock_time_nxt;
  logic [39:0]   total_wait_r, total_wait_nxt;
  logic [39:0]   total_turn_r, total_turn_nxt;

  logic [1:0]    res_status_r, res_status_nxt;
  logic [4:0]    res_id_r, res_id_nxt;
  logic          res_fin_r, res_fin_nxt;
  logic [31:0]   res_turn_r, res_turn_nxt;
  logic [31:0]   res_wait_r, res_wait_nxt;
  logic [31:0]   res_now_r, res_now_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r;
  logic [4:0]    out_job_id_r;
  logic          out_job_finished_r;
  logic [31:0]   out_turnaround_r, out_waiting_r, out_time_now_r;
  logic [4:0]    out_done_count_r;
  logic          out_all_done_r;
  logic [39:0]   out_waiting_sum_r, out_turnaround_sum_r;
  logic          out_load;

  slot_t         mem [SLOTS];
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  slot_t         mem_wdata;
  logic [IW-1:0] rd_addr;
  logic          issuing;

  pick_ctl_t     pick_ctl;
  logic          pick_found;
  logic [IW-1:0] pick_idx;
  slot_t         pick_best;

  logic [31:0]   clock_inc;
  logic [40:0]   wait_acc, turn_acc;

  srtf_pick #(.IW(IW)) u_pick (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (pick_ctl),
    .cand_idx   (rd_idx_r),
    .cand       (rd_data_r),
    .clock_time (clock_time_r),
    .found      (pick_found),
    .best_idx   (pick_idx),
    .best       (pick_best)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign issuing  = (state_r == ST_SCAN) && (issue_idx_r < jobs_stored_r);
  assign rd_addr  = issue_idx_r[IW-1:0];
  assign clock_inc = (clock_time_r == TIME_MAX) ? clock_time_r : clock_time_r + 32'd1;
  assign wait_acc = {1'b0, total_wait_r} + {9'd0, res_wait_r};
  assign turn_acc = {1'b0, total_turn_r} + {9'd0, res_turn_r};

  always_comb begin
    state_nxt          = state_r;
    issue_idx_nxt      = issue_idx_r;
    jobs_stored_nxt    = jobs_stored_r;
    jobs_completed_nxt = jobs_completed_r;
    clock_time_nxt     = clock_time_r;
    total_wait_nxt     = total_wait_r;
    total_turn_nxt     = total_turn_r;
    res_status_nxt     = res_status_r;
    res_id_nxt         = res_id_r;
    res_fin_nxt        = res_fin_r;
    res_turn_nxt       = res_turn_r;
    res_wait_nxt       = res_wait_r;
    res_now_nxt        = res_now_r;
    out_valid_nxt      = out_valid_r && !out_ready;
    out_load           = 1'b0;
    mem_we             = 1'b0;
    mem_waddr          = jobs_stored_r[IW-1:0];
    mem_wdata          = '{arrival: in_arrival, burst: in_burst, remaining: in_burst};
    pick_ctl           = '{clr: 1'b0, vld: rd_vld_r};

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_status_nxt = STAT_OK;
          res_id_nxt     = 5'd0;
          res_fin_nxt    = 1'b0;
          res_turn_nxt   = 32'd0;
          res_wait_nxt   = 32'd0;
          res_now_nxt    = clock_time_r;
          case (in_kind)
            KIND_CLEAR: begin
              jobs_stored_nxt    = '0;
              jobs_completed_nxt = '0;
              clock_time_nxt     = 32'd0;
              total_wait_nxt     = 40'd0;
              total_turn_nxt     = 40'd0;
              res_now_nxt        = 32'd0;
              state_nxt          = ST_RESULT;
            end
            KIND_ADD: begin
              if (jobs_stored_r >= FULL) begin
                res_status_nxt = STAT_FULL;
              end else if (in_burst == 16'd0) begin
                res_status_nxt = STAT_ZERO;
              end else begin
                mem_we          = 1'b1;
                jobs_stored_nxt = jobs_stored_r + CW'(1);
                res_id_nxt      = 5'({1'b0, jobs_stored_r[IW-1:0]} + (IW+1)'(1));
              end
              state_nxt = ST_RESULT;
            end
            KIND_TICK: begin
              issue_idx_nxt = '0;
              pick_ctl.clr  = 1'b1;
              state_nxt     = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (issuing) begin
          issue_idx_nxt = issue_idx_r + CW'(1);
        end else if (!rd_vld_r) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        clock_time_nxt = clock_inc;
        if (!pick_found) begin
          res_status_nxt = STAT_IDLE;
          state_nxt      = ST_RESULT;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = pick_idx;
          mem_wdata  = '{arrival: pick_best.arrival, burst: pick_best.burst,
                         remaining: pick_best.remaining - 16'd1};
          res_id_nxt = 5'({1'b0, pick_idx} + (IW+1)'(1));
          if (pick_best.remaining == 16'd1) begin
            res_fin_nxt  = 1'b1;
            res_turn_nxt = clock_inc - {16'd0, pick_best.arrival};
            state_nxt    = ST_WAITC;
          end else begin
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_WAITC: begin
        res_wait_nxt = (res_turn_r > {16'd0, pick_best.burst})
                     ? res_turn_r - {16'd0, pick_best.burst} : 32'd0;
        jobs_completed_nxt = jobs_completed_r + CW'(1);
        state_nxt = ST_SUMS;
      end
      ST_SUMS: begin
        total_wait_nxt = wait_acc[40] ? SUM_MAX : wait_acc[39:0];
        total_turn_nxt = turn_acc[40] ? SUM_MAX : turn_acc[39:0];
        state_nxt      = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      issue_idx_r      <= '0;
      rd_vld_r         <= 1'b0;
      jobs_stored_r    <= '0;
      jobs_completed_r <= '0;
      clock_time_r     <= 32'd0;
      total_wait_r     <= 40'd0;
      total_turn_r     <= 40'd0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      issue_idx_r      <= issue_idx_nxt;
      rd_vld_r         <= issuing;
      jobs_stored_r    <= jobs_stored_nxt;
      jobs_completed_r <= jobs_completed_nxt;
      clock_time_r     <= clock_time_nxt;
      total_wait_r     <= total_wait_nxt;
      total_turn_r     <= total_turn_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_fin_r    <= res_fin_nxt;
    res_turn_r   <= res_turn_nxt;
    res_wait_r   <= res_wait_nxt;
    res_now_r    <= res_now_nxt;
    rd_idx_r     <= rd_addr;
    rd_data_r    <= mem[rd_addr];
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (out_load) begin
      out_status_r         <= res_status_r;
      out_job_id_r         <= res_id_r;
      out_job_finished_r   <= res_fin_r;
      out_turnaround_r     <= res_turn_r;
      out_waiting_r        <= res_wait_r;
      out_time_now_r       <= res_now_r;
      out_done_count_r     <= 5'(jobs_completed_r);
      out_all_done_r       <= (jobs_completed_r == jobs_stored_r);
      out_waiting_sum_r    <= total_wait_r;
      out_turnaround_sum_r <= total_turn_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_job_id         = out_job_id_r;
  assign out_job_finished   = out_job_finished_r;
  assign out_turnaround     = out_turnaround_r;
  assign out_waiting        = out_waiting_r;
  assign out_time_now       = out_time_now_r;
  assign out_done_count     = out_done_count_r;
  assign out_all_done       = out_all_done_r;
  assign out_waiting_sum    = out_waiting_sum_r;
  assign out_turnaround_sum = out_turnaround_sum_r;

  // completed jobs never outnumber stored ones
  `SRTF_ASSERT_ALWAYS(a_done_le_stored, !rst_n || jobs_completed_r <= jobs_stored_r, "done > stored")
  // a tick beat starts a scan
  `SRTF_ASSERT(a_tick_scans, in_valid && in_ready && in_kind == KIND_TICK |=> state_r == ST_SCAN, "no scan")
  // the chosen job still has work left
  `SRTF_ASSERT(a_pick_live, state_r == ST_DECIDE && pick_found |-> pick_best.remaining != 16'd0, "dead pick")
  // a tick always leaves time nonzero
  `SRTF_ASSERT(a_time_moves, state_r == ST_DECIDE |=> clock_time_r != 32'd0, "time did not advance")

endmodule

`default_nettype wire
